// ===== sv/ubad_pkg.sv =====
// ----------------------------------------------------------------------------
// ubad_pkg
// Shared widths, access codes, target codes, I/O page addresses and the
// controller-to-datapath command type for the Unibus address decoder.
// ----------------------------------------------------------------------------
package ubad_pkg;

	localparam int OP_W   = 3;
	localparam int ADDR_W = 18;
	localparam int DATA_W = 16;
	localparam int TGT_W  = 4;

	// access codes
	localparam logic [OP_W-1:0] OP_CPU_RD_WORD  = 3'd0;
	localparam logic [OP_W-1:0] OP_CPU_WR_WORD  = 3'd1;
	localparam logic [OP_W-1:0] OP_CPU_RD_BYTE  = 3'd2;
	localparam logic [OP_W-1:0] OP_CPU_WR_BYTE  = 3'd3;
	localparam logic [OP_W-1:0] OP_DMA_RD       = 3'd4;
	localparam logic [OP_W-1:0] OP_DMA_WR       = 3'd5;

	// target register codes
	localparam logic [TGT_W-1:0] TGT_NONE    = 4'd0;
	localparam logic [TGT_W-1:0] TGT_SWITCH  = 4'd1;
	localparam logic [TGT_W-1:0] TGT_SR1     = 4'd2;
	localparam logic [TGT_W-1:0] TGT_CLKCSR  = 4'd3;
	localparam logic [TGT_W-1:0] TGT_SR0     = 4'd4;
	localparam logic [TGT_W-1:0] TGT_SR2     = 4'd5;
	localparam logic [TGT_W-1:0] TGT_PSW     = 4'd6;
	localparam logic [TGT_W-1:0] TGT_CONSOLE = 4'd7;
	localparam logic [TGT_W-1:0] TGT_DISK    = 4'd8;
	localparam logic [TGT_W-1:0] TGT_MMU     = 4'd9;

	// I/O page addresses and decode masks
	localparam logic [ADDR_W-1:0] IO_BASE       = 18'o760000;
	localparam logic [ADDR_W-1:0] A_CLKCSR      = 18'o777546;
	localparam logic [ADDR_W-1:0] A_SWITCH      = 18'o777570;
	localparam logic [ADDR_W-1:0] A_SR0         = 18'o777572;
	localparam logic [ADDR_W-1:0] A_SR1         = 18'o777574;
	localparam logic [ADDR_W-1:0] A_SR2         = 18'o777576;
	localparam logic [ADDR_W-1:0] A_PSW         = 18'o777776;
	localparam logic [ADDR_W-1:0] M_CONSOLE     = 18'o777770;
	localparam logic [ADDR_W-1:0] A_CONSOLE     = 18'o777560;
	localparam logic [ADDR_W-1:0] M_DISK        = 18'o777760;
	localparam logic [ADDR_W-1:0] A_DISK        = 18'o777400;
	localparam logic [ADDR_W-1:0] M_MMU         = 18'o777600;
	localparam logic [ADDR_W-1:0] A_MMU_KERNEL  = 18'o772200;
	localparam logic [ADDR_W-1:0] A_MMU_TOP     = 18'o777600;

	// writable bits of the clock status register
	localparam logic [DATA_W-1:0] CLKCSR_MASK = 16'o000300;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;   // latch the accepted item and read memory
		logic execute;   // finish the access and load the result register
	} ubad_cmd_t;

endpackage

// ===== sv/ubad_req_if.sv =====
// ----------------------------------------------------------------------------
// ubad_req_if
// Request channel: one bus access per transfer.
// ----------------------------------------------------------------------------
interface ubad_req_if;
	import ubad_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;
	logic [DATA_W-1:0] device_word;

	modport source (output valid, op, address, write_data, device_word, input ready);
	modport sink   (input valid, op, address, write_data, device_word, output ready);
endinterface

// ===== sv/ubad_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ubad_rsp_if
// Response channel: one result per access.
// ----------------------------------------------------------------------------
interface ubad_rsp_if;
	import ubad_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              bus_error;
	logic [TGT_W-1:0]  target;
	logic              device_write;
	logic [DATA_W-1:0] device_data;

	modport source (output valid, read_data, bus_error, target, device_write, device_data,
		input ready);
	modport sink   (input valid, read_data, bus_error, target, device_write, device_data,
		output ready);
endinterface

// ===== sv/ubad_ctrl.sv =====
// ----------------------------------------------------------------------------
// ubad_ctrl
// Controller: accepts one access, lets the datapath finish it once the
// result register is free, and tracks the result register's valid flag.
// ----------------------------------------------------------------------------
module ubad_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ubad_pkg::ubad_cmd_t cmd
);
	import ubad_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   exec_go;

	// finish the access when the result register is empty or draining
	assign exec_go     = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.execute = exec_go;

	// state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (exec_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

// ===== sv/ubad_dp.sv =====
// ----------------------------------------------------------------------------
// ubad_dp
// Datapath: item registers, main memory with a registered read port,
// I/O page decode, byte merge, and the result register.
// ----------------------------------------------------------------------------
module ubad_dp #(
	parameter int MEM_BYTES = 131072
) (
	input  logic                         clk,
	input  ubad_pkg::ubad_cmd_t          cmd,
	input  logic [ubad_pkg::OP_W-1:0]    op,
	input  logic [ubad_pkg::ADDR_W-1:0]  address,
	input  logic [ubad_pkg::DATA_W-1:0]  write_data,
	input  logic [ubad_pkg::DATA_W-1:0]  device_word,
	output logic [ubad_pkg::DATA_W-1:0]  read_data,
	output logic                         bus_error,
	output logic [ubad_pkg::TGT_W-1:0]   target,
	output logic                         device_write,
	output logic [ubad_pkg::DATA_W-1:0]  device_data
);
	import ubad_pkg::*;

	localparam int MEM_WORDS = (MEM_BYTES + 1) / 2;
	localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam logic [ADDR_W-1:0] MEM_LIMIT = ADDR_W'(MEM_BYTES);

	logic [DATA_W-1:0] mem_q [MEM_WORDS];
	logic [DATA_W-1:0] mem_rd_q;

	logic [OP_W-1:0]   op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] wdata_q;
	logic [DATA_W-1:0] dev_q;

	logic [DATA_W-1:0] rdata_q;
	logic              err_q;
	logic [TGT_W-1:0]  tgt_q;
	logic              dwr_q;
	logic [DATA_W-1:0] ddata_q;

	logic [ADDR_W-1:0] addr_even;
	logic              odd;
	logic              inmem;
	logic [TGT_W-1:0]  tgt_io;
	logic [DATA_W-1:0] io_val;
	logic              io_wr_ok;
	logic [DATA_W-1:0] word_in;
	logic [DATA_W-1:0] merged;
	logic [DATA_W-1:0] fwd_word;

	logic [DATA_W-1:0] n_rdata;
	logic              n_err;
	logic [TGT_W-1:0]  n_tgt;
	logic              n_dwr;
	logic [DATA_W-1:0] n_ddata;
	logic              mem_we;
	logic [DATA_W-1:0] mem_wdata;

	// I/O page register decode of an even address
	function automatic logic [TGT_W-1:0] decode_io(input logic [ADDR_W-1:0] a);
		logic [TGT_W-1:0] t;
		if (a == A_CLKCSR)                                    t = TGT_CLKCSR;
		else if (a == A_SWITCH)                               t = TGT_SWITCH;
		else if (a == A_SR0)                                  t = TGT_SR0;
		else if (a == A_SR1)                                  t = TGT_SR1;
		else if (a == A_SR2)                                  t = TGT_SR2;
		else if (a == A_PSW)                                  t = TGT_PSW;
		else if ((a & M_CONSOLE) == A_CONSOLE)                t = TGT_CONSOLE;
		else if ((a & M_DISK) == A_DISK)                      t = TGT_DISK;
		else if ((a & M_MMU) == A_MMU_KERNEL ||
			(a & M_MMU) == A_MMU_TOP)                         t = TGT_MMU;
		else                                                  t = TGT_NONE;
		return t;
	endfunction

	// item capture and memory read at acceptance
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op;
			addr_q   <= address;
			wdata_q  <= write_data;
			dev_q    <= device_word;
			mem_rd_q <= mem_q[address[AW:1]];
		end
	end

	// memory write port
	always_ff @(posedge clk) begin
		if (cmd.execute && mem_we) mem_q[addr_q[AW:1]] <= mem_wdata;
	end

	// address classification
	assign odd       = addr_q[0];
	assign addr_even = {addr_q[ADDR_W-1:1], 1'b0};
	assign inmem     = addr_q < MEM_LIMIT;
	assign tgt_io    = (addr_even >= IO_BASE) ? decode_io(addr_even) : TGT_NONE;
	assign io_val    = (tgt_io == TGT_SWITCH || tgt_io == TGT_SR1) ? '0 : dev_q;
	assign io_wr_ok  = (tgt_io != TGT_NONE) && (tgt_io != TGT_SR1) && (tgt_io != TGT_SR2);

	// byte merge into the containing word
	assign word_in = inmem ? mem_rd_q : io_val;
	assign merged  = odd ? {wdata_q[7:0], word_in[7:0]} : {word_in[15:8], wdata_q[7:0]};

	// access result
	always_comb begin
		n_rdata   = '0;
		n_err     = 1'b0;
		n_tgt     = TGT_NONE;
		n_dwr     = 1'b0;
		n_ddata   = '0;
		mem_we    = 1'b0;
		mem_wdata = wdata_q;
		fwd_word  = wdata_q;
		case (op_q)
			OP_CPU_RD_WORD: begin
				if (odd) n_err = 1'b1;
				else if (inmem) n_rdata = mem_rd_q;
				else if (tgt_io != TGT_NONE) begin
					n_tgt   = tgt_io;
					n_rdata = io_val;
				end else n_err = 1'b1;
			end
			OP_CPU_WR_WORD, OP_CPU_WR_BYTE: begin
				if (op_q == OP_CPU_WR_BYTE) begin
					fwd_word  = merged;
					mem_wdata = merged;
				end
				if (odd && op_q == OP_CPU_WR_WORD) n_err = 1'b1;
				else if (inmem) mem_we = 1'b1;
				else if (io_wr_ok) begin
					n_tgt = tgt_io;
					if (tgt_io != TGT_SWITCH) begin
						n_dwr   = 1'b1;
						n_ddata = (tgt_io == TGT_CLKCSR) ? (fwd_word & CLKCSR_MASK) : fwd_word;
					end
				end else n_err = 1'b1;
			end
			OP_CPU_RD_BYTE: begin
				if (inmem || tgt_io != TGT_NONE) begin
					n_tgt   = inmem ? TGT_NONE : tgt_io;
					n_rdata = odd ? {8'h00, word_in[15:8]} : {8'h00, word_in[7:0]};
				end else n_err = 1'b1;
			end
			OP_DMA_RD: begin
				if (odd || !inmem) n_err = 1'b1;
				else n_rdata = mem_rd_q;
			end
			OP_DMA_WR: begin
				if (odd || !inmem) n_err = 1'b1;
				else mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			rdata_q <= n_rdata;
			err_q   <= n_err;
			tgt_q   <= n_tgt;
			dwr_q   <= n_dwr;
			ddata_q <= n_ddata;
		end
	end

	assign read_data    = rdata_q;
	assign bus_error    = err_q;
	assign target       = tgt_q;
	assign device_write = dwr_q;
	assign device_data  = ddata_q;
endmodule

// ===== sv/unibus_address_decode_memory.sv =====
// ----------------------------------------------------------------------------
// unibus_address_decode_memory
// Unibus address decoder with main memory and I/O page target decode.
// ----------------------------------------------------------------------------
// Each access has a capture step and an execute step: the transfer cycle reads
// main memory at the captured word address into a registered read port, and
// the execute state then decodes the I/O page, merges bytes, writes memory
// back and loads the result register. Because of this read-then-write step,
// a new access is not accepted until the last one has finished. The result
// register holds a finished result while the next access is accepted; that
// access waits in its execute state until the result register is taken. Main
// memory has no reset: a word reads back only after it has been written.
module unibus_address_decode_memory #(
	parameter int MEM_BYTES = 131072
) (
	input  logic              clk,
	input  logic              arst_n,
	ubad_req_if.sink          req,
	ubad_rsp_if.source        rsp
);
	import ubad_pkg::*;

	ubad_cmd_t cmd;

	ubad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	ubad_dp #(
		.MEM_BYTES (MEM_BYTES)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.op           (req.op),
		.address      (req.address),
		.write_data   (req.write_data),
		.device_word  (req.device_word),
		.read_data    (rsp.read_data),
		.bus_error    (rsp.bus_error),
		.target       (rsp.target),
		.device_write (rsp.device_write),
		.device_data  (rsp.device_data)
	);

	// a transfer in closes the request side for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while an access is in progress");

	// a bus error clears every other result field
	a_error_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.bus_error |-> rsp.read_data == '0 && rsp.target == TGT_NONE &&
			!rsp.device_write && rsp.device_data == '0)
		else $error("bus error with nonzero result fields");

	// forwarding only to a writable decoded register
	a_forward_target: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.device_write |-> rsp.target != TGT_NONE &&
			rsp.target != TGT_SWITCH && rsp.target != TGT_SR1 && rsp.target != TGT_SR2)
		else $error("write forwarded to a register that takes none");

	// no forwarded data without a forwarded write
	a_forward_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.device_write |-> rsp.device_data == '0)
		else $error("forwarded data without a device write");
endmodule
